// ===== hw/rtl/ilir_pkg.sv =====
// Shared constants, codes and controller/datapath command types for the indexed list.
package ilir_pkg;

  // List geometry
  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed port widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int DPOS_W   = 4;
  localparam int RDV_W    = 32;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture request fields
    logic exec;   // apply request to the list and register the result
  } ilir_cmd_t;

endpackage

// ===== hw/rtl/ilir_ctrl.sv =====
// Controller: request handshake, execute sequencing and result strobe.
module ilir_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output ilir_pkg::ilir_cmd_t cmd
);
  import ilir_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Decode handshake and commands
  assign busy     = (state == S_EXEC);
  assign cmd.load = start && !busy;
  assign cmd.exec = (state == S_EXEC);

  // Advance state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state; raise the strobe the cycle after execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  a_exec_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("execute did not finish in one cycle with a strobe");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding execute");

endmodule

// ===== hw/rtl/ilir_dp.sv =====
// Datapath: request registers, list cells with shift paths, count and result registers.
module ilir_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ilir_pkg::ilir_cmd_t          cmd,
  input  logic [ilir_pkg::OP_W-1:0]    op,
  input  logic [ilir_pkg::POS_W-1:0]   position,
  input  logic [ilir_pkg::VAL_W-1:0]   value,
  output logic [ilir_pkg::STAT_W-1:0]  status,
  output logic [ilir_pkg::DPOS_W-1:0]  done_position,
  output logic [ilir_pkg::RDV_W-1:0]   read_value,
  output logic [ilir_pkg::CNT_W-1:0]   count
);
  import ilir_pkg::*;

  // Captured request
  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] val_q;

  // List cells and neighbor views
  logic [WORD_WIDTH-1:0] entries      [DEPTH];
  logic [WORD_WIDTH-1:0] entries_next [DEPTH];
  logic [WORD_WIDTH-1:0] lower_nb     [DEPTH];
  logic [WORD_WIDTH-1:0] upper_nb     [DEPTH];

  logic [CNT_W-1:0]      count_next;
  logic [STAT_W-1:0]     status_next;
  logic [PTR_W-1:0]      dpos_next;
  logic [WORD_WIDTH-1:0] rd_next;

  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;
  logic                  is_full;
  logic                  pos_lt;
  logic                  pos_gt;
  logic                  pos_eq;
  logic                  do_write;
  logic                  do_insert;
  logic                  do_remove;
  logic [PTR_W-1:0]      wr_idx;
  logic [PTR_W-1:0]      pos_idx;

  // Capture request on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      pos_q <= position;
      val_q <= WORD_WIDTH'(value);
    end
  end

  // Build fixed neighbor taps for the shift paths
  always_comb begin
    lower_nb[0]       = entries[0];
    upper_nb[DEPTH-1] = entries[DEPTH-1];
    for (int i = 1; i < DEPTH; i++) begin
      lower_nb[i]   = entries[i-1];
      upper_nb[i-1] = entries[i];
    end
  end

  // Compare position against count
  assign pos_c   = CMP_W'(pos_q);
  assign cnt_c   = CMP_W'(count);
  assign is_full = (count == CNT_W'(DEPTH));
  assign pos_lt  = (pos_c < cnt_c);
  assign pos_gt  = (pos_c > cnt_c);
  assign pos_eq  = (pos_c == cnt_c);
  assign pos_idx = pos_q[PTR_W-1:0];

  // Decode the operation
  always_comb begin
    status_next = ST_DONE;
    dpos_next   = '0;
    rd_next     = '0;
    count_next  = count;
    do_write    = 1'b0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    wr_idx      = pos_idx;
    case (op_q)
      OP_READ: begin
        if (!pos_lt) begin
          status_next = ST_RANGE;
        end else begin
          rd_next   = entries[pos_idx];
          dpos_next = pos_idx;
        end
      end
      OP_PUT: begin
        if (pos_gt) begin
          status_next = ST_RANGE;
        end else if (pos_eq && is_full) begin
          status_next = ST_FULL;
        end else begin
          do_write  = 1'b1;
          dpos_next = pos_idx;
          if (pos_eq) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      OP_INSERT: begin
        if (pos_gt) begin
          status_next = ST_RANGE;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          dpos_next  = pos_idx;
          count_next = count + CNT_W'(1);
        end
      end
      OP_APPEND: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_write   = 1'b1;
          wr_idx     = count[PTR_W-1:0];
          dpos_next  = count[PTR_W-1:0];
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!pos_lt) begin
          status_next = ST_RANGE;
        end else begin
          do_remove  = 1'b1;
          rd_next    = entries[pos_idx];
          dpos_next  = pos_idx;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // Choose each cell's next word from its own position compare
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_write && (wr_idx == PTR_W'(i))) begin
        entries_next[i] = val_q;
      end else if (do_insert) begin
        if (pos_c == CMP_W'(i)) begin
          entries_next[i] = val_q;
        end else if (pos_c < CMP_W'(i)) begin
          entries_next[i] = lower_nb[i];
        end
      end else if (do_remove && (pos_c <= CMP_W'(i))) begin
        entries_next[i] = upper_nb[i];
      end
    end
  end

  // Update cells
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  // Update count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= status_next;
      done_position <= DPOS_W'(dpos_next);
      read_value    <= RDV_W'(rd_next);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> (count == $past(count)))
    else $error("count changed outside execute");

endmodule

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// Indexed list: ordered list of DEPTH words with read, put, insert, append and remove.
// Timing: a request transferred from idle executes in the next cycle; done marks its
//   result in the cycle after execute.
// Requests: busy holds off a new request while one executes; results are never held off,
//   and the next request may transfer in the cycle a result shows.
// Reset: count clears to zero and busy drops; list words stay undefined until written.
module indexed_list_insert_remove (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ilir_pkg::OP_W-1:0]    op,
  input  logic [ilir_pkg::POS_W-1:0]   position,
  input  logic [ilir_pkg::VAL_W-1:0]   value,
  output logic                         done,
  output logic [ilir_pkg::STAT_W-1:0]  status,
  output logic [ilir_pkg::DPOS_W-1:0]  done_position,
  output logic [ilir_pkg::RDV_W-1:0]   read_value,
  output logic [ilir_pkg::CNT_W-1:0]   count
);
  import ilir_pkg::*;

  ilir_cmd_t cmd;

  // Sequence requests
  ilir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Hold the list and form results
  ilir_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (op),
    .position      (position),
    .value         (value),
    .status        (status),
    .done_position (done_position),
    .read_value    (read_value),
    .count         (count)
  );

endmodule
